// File: hdl/uartrx_pkg.sv
// shared types and constants for the serial receiver with line-end detection
package uartrx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_DATA,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       line_end;
    } rx_result_t;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned NBITS_W  = 4;
    localparam int unsigned TICK_W   = 17;

    localparam logic [TICK_W-1:0]   TICK_MAX       = 17'h1FFFF;
    localparam logic [7:0]          CHAR_CR        = 8'h0D;
    localparam logic [7:0]          CHAR_LF        = 8'h0A;
    localparam logic                REG_BIT_PERIOD = 1'b0;
    localparam logic                REG_DATA_BITS  = 1'b1;
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd434;
    localparam logic [NBITS_W-1:0]  DATA_BITS_RST  = 4'd8;

endpackage

// File: hdl/uartrx_core.sv
// receive state machine: one line sample per step, optional character result
module uartrx_core
    import uartrx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                level,
    input  logic [PERIOD_W-1:0] bit_period,
    input  logic [NBITS_W-1:0]  data_bits,
    output rx_result_t          result
);

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [NBITS_W-1:0]  idx_reg, idx_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          prev_reg, prev_next;
    logic                prev_valid_reg, prev_valid_next;

    logic [TICK_W-1:0]   first_wait;
    logic [TICK_W-1:0]   period_ext;
    logic [NBITS_W-1:0]  need;
    logic                done;
    logic                is_end;

    assign first_wait = {1'b0, bit_period} + {2'b00, bit_period[PERIOD_W-1:1]};
    assign period_ext = {1'b0, bit_period};
    assign need       = (data_bits == '0) ? NBITS_W'(1) : data_bits;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        shift_next      = shift_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        done            = 1'b0;
        is_end          = 1'b0;
        result          = '0;

        if (phase_next != PH_IDLE && tick_next != TICK_MAX)
        begin
            tick_next = tick_next + 1'b1;
        end

        if (phase_next == PH_FIRST && tick_next >= first_wait)
        begin
            phase_next = PH_DATA;
        end

        if (phase_next == PH_DATA && tick_next >= period_ext)
        begin
            if (!idx_next[NBITS_W-1])
            begin
                shift_next[idx_next[2:0]] = shift_next[idx_next[2:0]] | level;
            end
            idx_next  = idx_next + 1'b1;
            tick_next = '0;
            if (idx_next >= need)
            begin
                is_end          = prev_valid_reg && prev_reg == CHAR_CR
                                  && shift_next == CHAR_LF;
                result.valid    = 1'b1;
                result.data     = shift_next;
                result.line_end = is_end;
                done            = 1'b1;
                idx_next        = '0;
                if (is_end)
                begin
                    prev_next       = '0;
                    prev_valid_next = 1'b0;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    prev_next       = shift_next;
                    prev_valid_next = 1'b1;
                    phase_next      = PH_STOP;
                end
                shift_next = '0;
            end
        end

        if (!done)
        begin
            if (phase_next == PH_STOP && tick_next >= period_ext)
            begin
                phase_next = PH_IDLE;
            end
            if (phase_next == PH_IDLE && !level)
            begin
                phase_next = PH_FIRST;
                tick_next  = '0;
                idx_next   = '0;
                shift_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            idx_reg        <= '0;
            shift_reg      <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            idx_reg        <= idx_next;
            shift_reg      <= shift_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

endmodule

// File: hdl/uart_receiver_line_end.sv
// top level: line sample stream in, received character stream out, config port
//
// channel   dir  tdata                     tlast      tuser
// s_axis    in   [0] rx_level, [7:1] zero  -          -
// m_axis    out  [7:0] rx_byte             line_end   -
// cfg       in   index 0 bit_period[15:0], index 1 data_bits[3:0]
//
// one sample transaction per cycle while the output is not stalled
// a sample is held in the input register, its character (if any) is
// registered into the output register when the core consumes the sample
// reset clears receiver state and restores bit_period 434, data_bits 8
// s_axis_tready drops only while a sample is held and the output is stalled
module uart_receiver_line_end
    import uartrx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [0] rx_level
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tlast,   // line_end
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [PERIOD_W-1:0] cfg_wdata
);

    logic                in_valid_reg;
    logic                in_level_reg;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic                out_last_reg;
    logic [PERIOD_W-1:0] bit_period_reg;
    logic [NBITS_W-1:0]  data_bits_reg;
    logic                out_free;
    logic                consume;
    rx_result_t          result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RST;
            data_bits_reg  <= DATA_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_PERIOD: bit_period_reg <= cfg_wdata;
                REG_DATA_BITS:  data_bits_reg  <= cfg_wdata[NBITS_W-1:0];
                default:        bit_period_reg <= bit_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_level_reg <= s_axis_tdata[0];
        end
    end

    uartrx_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (consume),
        .level      (in_level_reg),
        .bit_period (bit_period_reg),
        .data_bits  (data_bits_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && result.valid)
        begin
            out_data_reg <= result.data;
            out_last_reg <= result.line_end;
        end
    end

    a_line_end_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CHAR_LF)
        else $error("line end flagged on a character other than LF");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without an output stall");

    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("character produced without a held sample");

endmodule

// File: tb/testbench.sv
// self-checking testbench for the serial receiver with CR LF line-end detection
module testbench
    import uartrx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       line_end;
    } rx_char_t;

    class char_scoreboard;
        logic [PERIOD_W-1:0] period = BIT_PERIOD_RST;
        logic [NBITS_W-1:0]  nbits  = DATA_BITS_RST;
        phase_t              ph     = PH_IDLE;
        logic [TICK_W-1:0]   ticks  = '0;
        logic [3:0]          bit_idx = '0;
        logic [7:0]          shift  = '0;
        logic [7:0]          prev   = '0;
        bit                  prev_ok = 1'b0;
        rx_char_t            pending_chars[$];
        int                  chars_predicted = 0;
        int                  errors = 0;

        function void write_reg(logic idx, logic [PERIOD_W-1:0] val);
            if (idx == REG_BIT_PERIOD)
                period = val;
            else
                nbits = val[NBITS_W-1:0];
        endfunction

        // one accepted line sample transaction
        function void note_sample(logic lvl);
            logic [TICK_W-1:0] first_wait;
            logic [3:0]        need;
            rx_char_t          got;
            first_wait = {1'b0, period} + {2'b00, period[PERIOD_W-1:1]};
            need = (nbits == 0) ? 4'd1 : nbits;
            if (ph != PH_IDLE && ticks != TICK_MAX)
                ticks++;
            if (ph == PH_FIRST && ticks >= first_wait)
                ph = PH_DATA;
            if (ph == PH_DATA && ticks >= {1'b0, period})
            begin
                if (bit_idx < 8)
                    shift[bit_idx[2:0]] = shift[bit_idx[2:0]] | lvl;
                bit_idx = bit_idx + 4'd1;
                ticks = '0;
                if (bit_idx >= need)
                begin
                    got.code = shift;
                    got.line_end = prev_ok && prev == CHAR_CR && shift == CHAR_LF;
                    pending_chars.push_back(got);
                    chars_predicted++;
                    shift = '0;
                    bit_idx = '0;
                    if (got.line_end)
                    begin
                        prev = '0;
                        prev_ok = 1'b0;
                        ph = PH_IDLE;
                    end
                    else
                    begin
                        prev = got.code;
                        prev_ok = 1'b1;
                        ph = PH_STOP;
                    end
                    return;
                end
            end
            if (ph == PH_STOP && ticks >= {1'b0, period})
                ph = PH_IDLE;
            if (ph == PH_IDLE && lvl == 1'b0)
            begin
                ph = PH_FIRST;
                ticks = '0;
                bit_idx = '0;
                shift = '0;
            end
        endfunction

        // one accepted character transaction
        function void check_char(logic [7:0] code, logic flag);
            rx_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character %h line_end %b", $time, code, flag);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: rx_byte expected %h actual %h", $time, want.code, code);
                errors++;
            end
            if (flag !== want.line_end)
            begin
                $display("%0t: line_end expected %b actual %b", $time, want.line_end, flag);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [0] rx_level
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;   // [7:0] rx_byte
    logic                m_axis_tlast;   // line_end
    logic                cfg_we;
    logic                cfg_index;
    logic [PERIOD_W-1:0] cfg_wdata;

    char_scoreboard      board = new();
    logic [PERIOD_W-1:0] line_period = BIT_PERIOD_RST;
    logic [NBITS_W-1:0]  line_bits = DATA_BITS_RST;
    bit                  tx_gaps_on = 1'b0;
    bit                  rx_gaps_on = 1'b0;
    bit                  hold_request = 1'b0;
    int                  samples_sent = 0;

    uart_receiver_line_end i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int frame_bits();
        return (line_bits == 0) ? 1 : int'(line_bits);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0, 1:    return CHAR_CR;
            2, 3:    return CHAR_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_level(input logic lvl);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 7) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, lvl};
        do @(posedge clk); while (!s_axis_tready);
        board.note_sample(lvl);
        samples_sent++;
    endtask

    task automatic send_frame(input logic [14:0] bits, input int nbits, input int stop_ticks);
        int span;
        span = (line_period == 0) ? 1 : int'(line_period);
        repeat (span) send_level(1'b0);
        for (int i = 0; i < nbits; i++)
            repeat (span) send_level(bits[i]);
        repeat (stop_ticks) send_level(1'b1);
    endtask

    task automatic send_char(input logic [7:0] code, input int stop_ticks);
        send_frame({7'($urandom_range(0, 127)), code}, frame_bits(), stop_ticks);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_chars.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PERIOD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] period, input logic [NBITS_W-1:0] nbits);
        drain();
        write_reg(REG_BIT_PERIOD, period);
        write_reg(REG_DATA_BITS, {{(PERIOD_W-NBITS_W){1'b0}}, nbits});
        cfg_we <= 1'b0;
        line_period = period;
        line_bits = nbits;
    endtask

    // character side: random stalls plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_char(m_axis_tdata, m_axis_tlast);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = 300;
            end
            else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int span;
        int stop;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_BIT_PERIOD;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first character, CR LF, back-to-back after line end
        set_config(16'd0, 4'd8);
        send_char(CHAR_LF, 1);
        send_char(CHAR_CR, 1);
        send_char(CHAR_LF, 0);
        send_char(8'h00, 0);
        send_char(8'hFF, 1);
        send_char(CHAR_CR, 1);
        send_char(CHAR_CR, 1);
        send_char(CHAR_LF, 2);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        set_config(16'd4, 4'd5);
        send_char(8'h1F, 6);
        send_char(8'h00, 6);
        set_config(16'd2, 4'd0);
        send_frame(15'h0001, 1, 3);
        send_frame(15'h0000, 1, 3);
        set_config(16'd1, 4'd15);
        send_frame(15'h7FFF, 15, 2);
        send_frame(15'h5A5A, 15, 2);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_config(16'd7, 4'd5);
        send_char(8'h15, 0);

        // long hold-off on the character side while samples keep coming
        set_config(16'd0, 4'd8);
        hold_request = 1'b1;
        repeat (30) send_char(pick_char(), 1);

        while (samples_sent < 750 || board.chars_predicted < 48)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: span = $urandom_range(0, 6);
                6, 7, 8:          span = $urandom_range(7, 16);
                default:          span = $urandom_range(17, 40);
            endcase
            set_config(16'(span), 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                                 : $urandom_range(5, 8)));
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (span == 0)
                span = 1;
            repeat ($urandom_range(4, 10))
            begin
                case ($urandom_range(0, 9))
                    0:
                        repeat ($urandom_range(1, 20)) send_level(1'($urandom_range(0, 1)));
                    1:
                    begin
                        send_frame(15'($urandom_range(0, 32767)),
                                   $urandom_range(0, frame_bits() - 1), 0);
                        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
                    end
                    default:
                    begin
                        stop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span)
                                                           : span + $urandom_range(0, span);
                        send_char(pick_char(), stop);
                    end
                endcase
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending_chars.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
